/* hw/rtl/sphere_overlap_horizontal_pushout_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef SPHERE_OVERLAP_HORIZONTAL_PUSHOUT_ASSERT_SVH
`define SPHERE_OVERLAP_HORIZONTAL_PUSHOUT_ASSERT_SVH

// Condition a implies c in the same cycle.
`define SOHP_ASSERT_NOW(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
		else $error("sohp assertion failed");

// Condition a implies c in the next cycle.
`define SOHP_ASSERT_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
		else $error("sohp assertion failed");

`endif

/* hw/rtl/sohp_pkg.sv */
package sohp_pkg;

	localparam int CoordBits = 32;
	localparam int DiffBits  = CoordBits + 1;

	typedef struct packed {
		logic signed [CoordBits-1:0] a_x;
		logic signed [CoordBits-1:0] a_y;
		logic signed [CoordBits-1:0] a_z;
		logic [CoordBits-2:0]        a_radius;
		logic signed [CoordBits-1:0] b_x;
		logic signed [CoordBits-1:0] b_y;
		logic signed [CoordBits-1:0] b_z;
		logic [CoordBits-2:0]        b_radius;
	} pair_t;

	typedef struct packed {
		logic                        hit;
		logic signed [CoordBits-1:0] push_x;
		logic signed [CoordBits-1:0] push_z;
	} resp_t;

	// carried alongside the square-root cells
	typedef struct packed {
		logic                hit;
		logic                sx;
		logic                sz;
		logic [DiffBits-1:0] mx;
		logic [DiffBits-1:0] mz;
	} sq_side_t;

	// carried alongside the divider cells
	typedef struct packed {
		logic                 hit;
		logic                 zero;
		logic                 sx;
		logic                 sz;
		logic [CoordBits-1:0] dv;
	} dv_side_t;

endpackage

/* hw/rtl/sohp_sqrt_cell.sv */
module sohp_sqrt_cell
	import sohp_pkg::*;
#(
	parameter int SW  = 68,
	parameter int RW  = 34,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [SW-1:0] rem_in,
	input  logic [RW-1:0] root_in,
	output logic [SW-1:0] rem_out,
	output logic [RW-1:0] root_out
);

	logic [SW-1:0] trial;
	logic          take;

	assign trial = (SW'(root_in) << (BIT + 1)) + (SW'(1) << (2 * BIT));
	assign take  = rem_in >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? rem_in - trial : rem_in;
			root_out <= take ? (root_in | (RW'(1) << BIT)) : root_in;
		end
	end

endmodule

/* hw/rtl/sohp_div_cell.sv */
module sohp_div_cell
	import sohp_pkg::*;
#(
	parameter int NW  = 65,
	parameter int QW  = 32,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [QW-1:0] dv,
	input  logic [NW-1:0] rem_in,
	input  logic [QW-1:0] quo_in,
	output logic [NW-1:0] rem_out,
	output logic [QW-1:0] quo_out
);

	logic [NW-1:0] trial;
	logic          take;

	assign trial = NW'(dv) << BIT;
	assign take  = rem_in >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? rem_in - trial : rem_in;
			quo_out <= take ? (quo_in | (QW'(1) << BIT)) : quo_in;
		end
	end

endmodule

/* hw/rtl/sphere_overlap_horizontal_pushout.sv */
// Register path: stage 1, stage 2, root operands, root cells, multiply, divider cells, resp.
// Throughput: one word per cycle unless stalled; the whole cell chain advances together.
// Depth is set by the bit-serial square-root cells (CoordBits+2) and divider cells (CoordBits).
// resp_stall with resp_valid holds every stage and raises pair_stall in the same cycle.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
module sphere_overlap_horizontal_pushout
	import sohp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  pair_t pair,
	input  logic  pair_valid,
	output logic  pair_stall,
	output resp_t resp,
	output logic  resp_valid,
	input  logic  resp_stall
);

	localparam int C  = CoordBits;
	localparam int DW = DiffBits;
	localparam int SW = 2 * C + 4;
	localparam int RW = C + 2;
	localparam int NW = 2 * C + 1;

	logic en;
	assign en         = !(resp_valid && resp_stall);
	assign pair_stall = !en;

	// stage 1: differences and radius sum
	logic [DW-1:0] dx_c, dy_c, dz_c;
	logic          v_s1, sx_s1, sz_s1;
	logic [DW-1:0] mx_s1, my_s1, mz_s1;
	logic [C-1:0]  rng_s1;

	assign dx_c = {pair.a_x[C-1], pair.a_x} - {pair.b_x[C-1], pair.b_x};
	assign dy_c = {pair.a_y[C-1], pair.a_y} - {pair.b_y[C-1], pair.b_y};
	assign dz_c = {pair.a_z[C-1], pair.a_z} - {pair.b_z[C-1], pair.b_z};

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= dx_c[DW-1];
			sz_s1  <= dz_c[DW-1];
			mx_s1  <= dx_c[DW-1] ? -dx_c : dx_c;
			my_s1  <= dy_c[DW-1] ? -dy_c : dy_c;
			mz_s1  <= dz_c[DW-1] ? -dz_c : dz_c;
			rng_s1 <= C'(pair.a_radius) + C'(pair.b_radius);
		end
	end

	// stage 2: squares
	logic            v_s2, sx_s2, sz_s2;
	logic [DW-1:0]   mx_s2, mz_s2;
	logic [2*DW-1:0] hx_s2, hz_s2, vy_s2;
	logic [2*C-1:0]  rsq_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2  <= sx_s1;
			sz_s2  <= sz_s1;
			mx_s2  <= mx_s1;
			mz_s2  <= mz_s1;
			hx_s2  <= mx_s1 * mx_s1;
			hz_s2  <= mz_s1 * mz_s1;
			vy_s2  <= my_s1 * my_s1;
			rsq_s2 <= rng_s1 * rng_s1;
		end
	end

	// stage 3: hit test, square-root operands
	logic [SW-1:0] hsq_c, tot_c;
	logic          hit_c;

	assign hsq_c = SW'(hx_s2) + SW'(hz_s2);
	assign tot_c = hsq_c + SW'(vy_s2);
	assign hit_c = tot_c <= SW'(rsq_s2);

	logic [SW-1:0] h_rem  [0:RW];
	logic [RW-1:0] h_root [0:RW];
	logic [SW-1:0] n_rem  [0:RW];
	logic [RW-1:0] n_root [0:RW];
	sq_side_t      sq_side[0:RW];
	logic          sq_v   [0:RW];

	always_ff @(posedge clk) begin
		if (en) begin
			h_rem[0]   <= hsq_c;
			h_root[0]  <= '0;
			n_rem[0]   <= hit_c ? SW'(rsq_s2) - SW'(vy_s2) : '0;
			n_root[0]  <= '0;
			sq_side[0] <= '{hit: hit_c, sx: sx_s2, sz: sz_s2, mx: mx_s2, mz: mz_s2};
		end
	end

	genvar k;
	generate
		for (k = 0; k < RW; k++) begin : g_sq
			sohp_sqrt_cell #(.SW(SW), .RW(RW), .BIT(RW - 1 - k)) u_h (
				.clk(clk), .en(en),
				.rem_in(h_rem[k]), .root_in(h_root[k]),
				.rem_out(h_rem[k+1]), .root_out(h_root[k+1])
			);
			sohp_sqrt_cell #(.SW(SW), .RW(RW), .BIT(RW - 1 - k)) u_n (
				.clk(clk), .en(en),
				.rem_in(n_rem[k]), .root_in(n_root[k]),
				.rem_out(n_rem[k+1]), .root_out(n_root[k+1])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					sq_side[k+1] <= sq_side[k];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v[k+1] <= 1'b0;
				end else if (en) begin
					sq_v[k+1] <= sq_v[k];
				end
			end
		end
	endgenerate

	// multiply stage: push length times offset
	logic [RW-1:0] hr_c;
	logic [C-1:0]  len_c;
	logic          zero_c;

	assign hr_c   = h_root[RW];
	assign len_c  = C'(n_root[RW] - hr_c);
	assign zero_c = hr_c == '0;

	logic [NW-1:0] x_rem [0:C];
	logic [NW-1:0] z_rem [0:C];
	logic [C-1:0]  x_quo [0:C];
	logic [C-1:0]  z_quo [0:C];
	dv_side_t      dv_side[0:C];
	logic          dv_v  [0:C];

	always_ff @(posedge clk) begin
		if (en) begin
			x_rem[0]   <= NW'(sq_side[RW].mx) * NW'(len_c);
			z_rem[0]   <= NW'(sq_side[RW].mz) * NW'(len_c);
			x_quo[0]   <= '0;
			z_quo[0]   <= '0;
			// divide by one when horizontal distance is zero; result is dropped anyway
			dv_side[0] <= '{hit: sq_side[RW].hit, zero: zero_c, sx: sq_side[RW].sx,
				sz: sq_side[RW].sz, dv: zero_c ? C'(1) : C'(hr_c)};
		end
	end

	generate
		for (k = 0; k < C; k++) begin : g_dv
			sohp_div_cell #(.NW(NW), .QW(C), .BIT(C - 1 - k)) u_x (
				.clk(clk), .en(en), .dv(dv_side[k].dv),
				.rem_in(x_rem[k]), .quo_in(x_quo[k]),
				.rem_out(x_rem[k+1]), .quo_out(x_quo[k+1])
			);
			sohp_div_cell #(.NW(NW), .QW(C), .BIT(C - 1 - k)) u_z (
				.clk(clk), .en(en), .dv(dv_side[k].dv),
				.rem_in(z_rem[k]), .quo_in(z_quo[k]),
				.rem_out(z_rem[k+1]), .quo_out(z_quo[k+1])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					dv_side[k+1] <= dv_side[k];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v[k+1] <= 1'b0;
				end else if (en) begin
					dv_v[k+1] <= dv_v[k];
				end
			end
		end
	endgenerate

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			sq_v[0]  <= 1'b0;
			dv_v[0]  <= 1'b0;
		end else if (en) begin
			v_s1     <= pair_valid;
			v_s2     <= v_s1;
			sq_v[0]  <= v_s2;
			dv_v[0]  <= sq_v[RW];
		end
	end

	// saturate magnitude and apply sign
	function automatic logic [C-1:0] signed_sat(input logic neg, input logic [C-1:0] m);
		logic [C-1:0] lim;
		lim = C'(1) << (C - 1);
		if (neg) begin
			return (m > lim) ? lim : -m;
		end
		return (m > lim - C'(1)) ? lim - C'(1) : m;
	endfunction

	logic keep_c;
	assign keep_c = dv_side[C].hit && !dv_side[C].zero;

	always_ff @(posedge clk) begin
		if (en) begin
			resp.hit    <= dv_side[C].hit;
			resp.push_x <= keep_c ? signed_sat(dv_side[C].sx, x_quo[C]) : '0;
			resp.push_z <= keep_c ? signed_sat(dv_side[C].sz, z_quo[C]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid <= 1'b0;
		end else if (en) begin
			resp_valid <= dv_v[C];
		end
	end

endmodule

/* hw/rtl/sohp_checker.sv */
`include "sphere_overlap_horizontal_pushout_assert.svh"

module sohp_checker
	import sohp_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input pair_t pair,
	input logic  pair_valid,
	input logic  pair_stall,
	input resp_t resp,
	input logic  resp_valid,
	input logic  resp_stall
);

	// a miss never pushes
	`SOHP_ASSERT_NOW(a_miss_no_push, clk, arst_n, resp_valid && !resp.hit, resp.push_x == '0 && resp.push_z == '0)

	// input side stalls exactly when a result word is held
	`SOHP_ASSERT_NOW(a_stall_link, clk, arst_n, 1'b1, pair_stall == (resp_valid && resp_stall))

	// held result word stays put
	`SOHP_ASSERT_NEXT(a_resp_hold, clk, arst_n, resp_valid && resp_stall, resp_valid && $stable(resp))

endmodule

bind sphere_overlap_horizontal_pushout sohp_checker u_sohp_checker (.*);
